@@ rtl/ilha_pkg.sv @@
package ilha_pkg;

  localparam int unsigned TAG_BYTES = 4;
  localparam int unsigned MIN_BLOCK = 16;
  localparam int unsigned WALK_W = 34;
  localparam int unsigned WQ_DEPTH = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_F0    = 14'b00000000000100,
    S_F1    = 14'b00000000001000,
    S_WR    = 14'b00000000010000,
    S_M0    = 14'b00000000100000,
    S_M1    = 14'b00000001000000,
    S_M2    = 14'b00000010000000,
    S_M3    = 14'b00000100000000,
    S_WALK  = 14'b00001000000000,
    S_WALK1 = 14'b00010000000000,
    S_GROW  = 14'b00100000000000,
    S_T0    = 14'b01000000000000,
    S_T1    = 14'b10000000000000
  } state_t;

endpackage

@@ rtl/ilha_ram.sv @@
module ilha_ram
  #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/implicit_list_heap_allocator.sv @@
// boundary-tag heap allocator, first fit over an implicit block list
// command port: a word is taken when start is high and busy is low
//   operation 0 allocates request_size bytes, 1 frees the block at block_address
// each command returns exactly one result word: done is high for one cycle with
//   payload_address, granted_size and status valid in that cycle
// the receiver cannot stall; results are simply presented for that single cycle
// the heap lives in one single-port word ram with a registered read, so every
//   tag read, every tag write and every list hop takes its turn on that one port
// steps: a zero-size allocate answers from idle; a free reads the header,
//   clears the alloc bit in both tags, reads the neighbors' tags and merges
//   with any free one; an allocate walks the list first fit, grows the heap
//   when no block fits, then marks the block used, splitting off a free rest
// throughput: one command at a time, busy stays high through the done cycle
// reset: rst is synchronous; afterwards the ram is swept once, one word per
//   cycle over HEAP_BYTES/4 words, laying down the padding, the prologue, one
//   free chunk when it fits, the epilogue; busy stays high through the sweep
// the heap break only grows; growth past HEAP_BYTES reports out of memory
module implicit_list_heap_allocator
  import ilha_pkg::*;
  #(
    parameter int unsigned HEAP_BYTES = 65536,
    parameter int unsigned CHUNK_BYTES = 4096
  )
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        done,
    output logic [15:0] payload_address,
    output logic [16:0] granted_size,
    output logic [1:0]  status
  );

  // byte address width and word index width
  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned WAW = AW - 2;
  localparam int unsigned DEPTH = HEAP_BYTES / 4;
  localparam int unsigned BRK_W = AW + 1;
  localparam int unsigned GW = ((BRK_W > 18) ? BRK_W : 18) + 1;

  // initial chunk, rounded to an even number of words
  localparam int unsigned CB = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
  localparam bit INIT_OK = (16 + CB) <= HEAP_BYTES;
  localparam int unsigned INIT_BRK = INIT_OK ? (16 + CB) : 16;
  localparam int unsigned FOOT_IDX = INIT_OK ? (8 + CB) / 4 : 0;
  localparam int unsigned EPI_IDX = INIT_OK ? (12 + CB) / 4 : 0;
  localparam logic [31:0] HDR3_VAL = INIT_OK ? 32'(CB) : 32'd1;

  state_t state;
  state_t ret_state;

  logic [WAW-1:0]    clr_idx;
  logic              is_alloc;
  logic [AW-1:0]     ba;
  logic [16:0]       want;
  logic [WALK_W-1:0] p;
  logic [AW-1:0]     mp;
  logic [31:0]       s;
  logic [31:0]       q;
  logic [31:0]       qsz;
  logic              pu;
  logic [31:0]       blk;
  logic [BRK_W-1:0]  brk;
  logic [31:0]       have;

  // pending tag writes, drained one per cycle
  logic [AW-1:0]     wq_addr [WQ_DEPTH];
  logic [31:0]       wq_data [WQ_DEPTH];
  logic [1:0]        wq_idx;
  logic [1:0]        wq_last;

  logic [15:0]       res_pay;
  logic [16:0]       res_size;
  logic [1:0]        res_status;
  logic              res_valid;

  logic              ram_we;
  logic [AW-1:0]     ram_baddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;
  logic [31:0]       tsz;
  logic [31:0]       q_c;
  logic [31:0]       init_val;

  logic [16:0]       ext;
  logic [14:0]       ext_w;
  logic [GW-1:0]     grow_bytes;
  logic [GW-1:0]     grow_end;

  assign tsz = ram_rdata & ~32'h7;
  assign q_c = 32'(mp) - tsz;

  assign ext = (want > 17'(CHUNK_BYTES)) ? want : 17'(CHUNK_BYTES);
  assign ext_w = ext[16:2];
  assign grow_bytes = GW'({(15'(ext_w) + 15'(ext_w[0])), 2'b00});
  assign grow_end = GW'(brk) + grow_bytes;

  always_comb begin
    init_val = '0;
    if (clr_idx == WAW'(1) || clr_idx == WAW'(2)) begin
      init_val = 32'd9;
    end else if (clr_idx == WAW'(3)) begin
      init_val = HDR3_VAL;
    end else if (INIT_OK && clr_idx == WAW'(FOOT_IDX)) begin
      init_val = 32'(CB);
    end else if (INIT_OK && clr_idx == WAW'(EPI_IDX)) begin
      init_val = 32'd1;
    end
  end

  // ram port: one access per cycle, chosen by the sequencer state
  always_comb begin
    ram_we = 1'b0;
    ram_baddr = '0;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_baddr = {clr_idx, 2'b00};
        ram_wdata = init_val;
      end
      S_F0:    ram_baddr = ba - AW'(TAG_BYTES);
      S_WR: begin
        ram_we = 1'b1;
        ram_baddr = wq_addr[wq_idx];
        ram_wdata = wq_data[wq_idx];
      end
      S_M0:    ram_baddr = mp - AW'(8);
      S_M1:    ram_baddr = q_c[AW-1:0] - AW'(TAG_BYTES);
      S_M2:    ram_baddr = mp + s[AW-1:0] - AW'(TAG_BYTES);
      S_WALK:  ram_baddr = p[AW-1:0] - AW'(TAG_BYTES);
      S_T0:    ram_baddr = blk[AW-1:0] - AW'(TAG_BYTES);
      default: ram_baddr = '0;
    endcase
  end

  ilha_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_baddr[AW-1:2]),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign have = tsz;

  always_ff @(posedge clk) begin
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      brk <= BRK_W'(INIT_BRK);
      wq_idx <= '0;
      ret_state <= S_IDLE;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == WAW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          // no new word during the done cycle
          if (start && !busy) begin
            is_alloc <= (operation == OP_ALLOC);
            ba <= AW'(block_address);
            want <= (request_size <= 16'd8) ? 17'(MIN_BLOCK)
                    : 17'(({1'b0, request_size} + 17'd7) & ~17'd7) + 17'd8;
            p <= WALK_W'(8);
            if (operation == OP_FREE) begin
              state <= S_F0;
            end else if (request_size == 16'd0) begin
              res_pay <= '0;
              res_size <= '0;
              res_status <= ST_ZERO;
              res_valid <= 1'b1;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          // clear the alloc bit in header and footer, then merge
          s <= tsz;
          mp <= ba;
          res_size <= tsz[16:0];
          wq_addr[0] <= ba - AW'(TAG_BYTES);
          wq_data[0] <= tsz;
          wq_addr[1] <= ba + tsz[AW-1:0] - AW'(8);
          wq_data[1] <= tsz;
          wq_last <= 2'd1;
          wq_idx <= '0;
          ret_state <= S_M0;
          state <= S_WR;
        end
        S_WR: begin
          wq_idx <= wq_idx + 1'b1;
          if (wq_idx == wq_last) begin
            state <= ret_state;
            if (ret_state == S_IDLE) begin
              res_valid <= 1'b1;
            end
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          q <= q_c;
          state <= S_M2;
        end
        S_M2: begin
          pu <= ram_rdata[0];
          qsz <= tsz;
          state <= S_M3;
        end
        S_M3: begin
          wq_idx <= '0;
          wq_last <= 2'd1;
          ret_state <= is_alloc ? S_T0 : S_IDLE;
          if (pu && ram_rdata[0]) begin
            // both neighbors in use
            blk <= 32'(mp);
            if (is_alloc) begin
              state <= S_T0;
            end else begin
              state <= S_IDLE;
              res_valid <= 1'b1;
            end
          end else if (pu) begin
            // merge with the next block
            blk <= 32'(mp);
            wq_addr[0] <= mp - AW'(TAG_BYTES);
            wq_data[0] <= s + tsz;
            wq_addr[1] <= mp + AW'(s + tsz) - AW'(8);
            wq_data[1] <= s + tsz;
            state <= S_WR;
          end else if (ram_rdata[0]) begin
            // merge with the previous block
            blk <= q;
            wq_addr[0] <= mp + s[AW-1:0] - AW'(8);
            wq_data[0] <= s + qsz;
            wq_addr[1] <= q[AW-1:0] - AW'(TAG_BYTES);
            wq_data[1] <= s + qsz;
            state <= S_WR;
          end else begin
            // merge with both neighbors
            blk <= q;
            wq_addr[0] <= q[AW-1:0] - AW'(TAG_BYTES);
            wq_data[0] <= s + tsz + qsz;
            wq_addr[1] <= mp + s[AW-1:0] + tsz[AW-1:0] - AW'(8);
            wq_data[1] <= s + tsz + qsz;
            state <= S_WR;
          end
        end
        S_WALK: begin
          if (p < WALK_W'(brk)) begin
            state <= S_WALK1;
          end else begin
            state <= S_GROW;
          end
        end
        S_WALK1: begin
          if (tsz == 32'd0) begin
            state <= S_GROW;
          end else if (32'(want) <= tsz && !ram_rdata[0]) begin
            blk <= p[31:0];
            state <= S_T0;
          end else begin
            p <= p + WALK_W'(tsz);
            state <= S_WALK;
          end
        end
        S_GROW: begin
          if (grow_end > GW'(HEAP_BYTES)) begin
            res_pay <= '0;
            res_size <= '0;
            res_status <= ST_OOM;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            // new free block at the old break, new epilogue after it
            mp <= brk[AW-1:0];
            s <= 32'(grow_bytes);
            brk <= BRK_W'(grow_end);
            wq_addr[0] <= brk[AW-1:0] - AW'(TAG_BYTES);
            wq_data[0] <= 32'(grow_bytes);
            wq_addr[1] <= brk[AW-1:0] + AW'(grow_bytes) - AW'(8);
            wq_data[1] <= 32'(grow_bytes);
            wq_addr[2] <= brk[AW-1:0] + AW'(grow_bytes) - AW'(TAG_BYTES);
            wq_data[2] <= 32'd1;
            wq_last <= 2'd2;
            wq_idx <= '0;
            ret_state <= S_M0;
            state <= S_WR;
          end
        end
        S_T0: state <= S_T1;
        S_T1: begin
          res_pay <= blk[15:0];
          res_size <= want;
          res_status <= ST_OK;
          wq_idx <= '0;
          ret_state <= S_IDLE;
          state <= S_WR;
          if (have >= 32'(want) && (have - 32'(want)) >= 32'(MIN_BLOCK)) begin
            // split: allocated front, free remainder
            wq_addr[0] <= blk[AW-1:0] - AW'(TAG_BYTES);
            wq_data[0] <= 32'(want) | 32'd1;
            wq_addr[1] <= blk[AW-1:0] + AW'(want) - AW'(8);
            wq_data[1] <= 32'(want) | 32'd1;
            wq_addr[2] <= blk[AW-1:0] + AW'(want) - AW'(TAG_BYTES);
            wq_data[2] <= have - 32'(want);
            wq_addr[3] <= blk[AW-1:0] + AW'(have) - AW'(8);
            wq_data[3] <= have - 32'(want);
            wq_last <= 2'd3;
          end else begin
            wq_addr[0] <= blk[AW-1:0] - AW'(TAG_BYTES);
            wq_data[0] <= have | 32'd1;
            wq_addr[1] <= blk[AW-1:0] + have[AW-1:0] - AW'(8);
            wq_data[1] <= have | 32'd1;
            wq_last <= 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_F0) begin
        res_pay <= '0;
        res_status <= ST_OK;
      end
    end
  end

  assign busy = (state != S_IDLE) || res_valid;
  assign done = res_valid;
  assign payload_address = res_pay;
  assign granted_size = res_size;
  assign status = res_status;

endmodule
